>>> design/ssff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssff_pkg
// Shared constants and the segment lookup for the seven-segment field
// formatter.
// ----------------------------------------------------------------------------
package ssff_pkg;

    localparam int MAX_DIGITS_DEF  = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADING_ZEROS = 2'd1;

    localparam logic [4:0] DIGIT_COUNT_RST = 5'd4;
    localparam logic [3:0] BLANK_CODE      = 4'd10;
    localparam logic [5:0] END_MAX         = 6'd63;

    // reciprocal of ten, scaled by 2^35
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    function automatic logic [7:0] seg_of(input logic [3:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = 8'd63;
            4'd1:    seg = 8'd6;
            4'd2:    seg = 8'd91;
            4'd3:    seg = 8'd79;
            4'd4:    seg = 8'd102;
            4'd5:    seg = 8'd109;
            4'd6:    seg = 8'd125;
            4'd7:    seg = 8'd7;
            4'd8:    seg = 8'd127;
            4'd9:    seg = 8'd111;
            default: seg = 8'd0;
        endcase
        return seg;
    endfunction

endpackage

>>> design/seven_segment_field_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_field_formatter
// Formats decimal display fields into a digit store and shifts the frame out
// as seven-segment bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input: pulse i_start with a field (value, length, blank, last) while
//   o_busy is low; the field is taken at that edge. Fields fill the display
//   from its top end downwards.
//   Results: only a field marked last produces output. The block then emits
//   one segment byte per display digit, index 0 first, each on
//   o_segment_pattern for one cycle with o_strobe high; o_last_pattern marks
//   the final byte. The receiver cannot stall, so nothing is held back.
//   Steps: one divide-by-ten unit (reciprocal multiply) is reused for every
//   step. After the transfer the block counts the decimal digits of the
//   value (at most 10), drops the low digits that do not fit the field and
//   writes the field into the store; a last field then emits its frame.
//   o_busy stays high throughout, so no new field is taken meanwhile.
//   Configuration: i_cfg_valid/o_cfg_ready transfer at index 0 digit count,
//   at index 1 leading-zero enable; write only while o_busy is low.
//   Reset: store reads blank, placement restarts, digit count 4, leading
//   zeros off.
// ----------------------------------------------------------------------------
module seven_segment_field_formatter
    import ssff_pkg::*;
#(
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [4:0]             i_field_length,
    input  logic                   i_blank_field,
    input  logic                   i_last_field,
    output logic                   o_strobe,
    output logic [7:0]             o_segment_pattern,
    output logic                   o_last_pattern,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LEN   = 5'b00010,
        S_DROP  = 5'b00100,
        S_PLACE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                 r_state;
    logic [4:0]             r_digit_count;
    logic                   r_lz;
    logic [5:0]             r_fep;
    logic [5:0]             r_end;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] r_work;
    logic [4:0]             r_len;
    logic                   r_blank;
    logic                   r_last;
    logic [3:0]             r_vlen;
    logic [3:0]             r_cnt;
    logic [4:0]             r_j;
    logic [5:0]             r_oi;
    logic [MAX_DIGITS-1:0]  r_valid;
    logic [3:0]             r_store [MAX_DIGITS];
    logic                   r_strobe;
    logic [7:0]             r_seg;
    logic                   r_last_pat;

    logic [5:0]  w_digits;
    logic [31:0] w_work32;
    logic [63:0] w_prod;
    logic [28:0] w_q;
    logic [3:0]  w_rem;
    logic [6:0]  w_end_sum;
    logic [6:0]  w_pos_sum;
    logic [6:0]  w_pos_diff;
    logic        w_in_range;
    logic [IW-1:0] w_widx;
    logic [IW-1:0] w_ridx;
    logic [3:0]  w_code;
    logic [3:0]  w_rcode;
    logic        w_accept;
    logic        w_wr;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && (r_state == S_IDLE);

    always_comb begin
        if (r_digit_count == 5'd0) begin
            w_digits = 6'd1;
        end else if ({1'b0, r_digit_count} > 6'(MAX_DIGITS)) begin
            w_digits = 6'(MAX_DIGITS);
        end else begin
            w_digits = {1'b0, r_digit_count};
        end
    end

    // shared divide-by-ten: quotient by reciprocal, remainder from low bits
    assign w_work32 = 32'(r_work);
    assign w_prod   = 64'(w_work32) * 64'(RECIP_TEN);
    assign w_q      = w_prod[63:RECIP_SHIFT];
    assign w_rem    = 4'(w_work32[3:0] - {w_q[0], 3'b000} - {w_q[2:0], 1'b0});

    assign w_end_sum  = {1'b0, r_fep} + {2'b00, i_field_length};
    assign w_pos_sum  = {1'b0, w_digits} + {2'b00, r_j};
    assign w_pos_diff = w_pos_sum - {1'b0, r_end};
    assign w_in_range = (w_pos_sum >= {1'b0, r_end});
    assign w_widx     = w_pos_diff[IW-1:0];
    assign w_code     = (r_blank || ({1'b0, r_j} >= {2'b00, r_vlen} && !r_lz)) ?
                        BLANK_CODE : w_rem;
    assign w_wr       = (r_state == S_PLACE) && (r_j != r_len) && w_in_range;

    assign w_ridx  = r_oi[IW-1:0];
    assign w_rcode = r_valid[w_ridx] ? r_store[w_ridx] : BLANK_CODE;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[w_widx] <= w_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val   <= i_value;
            r_work  <= i_value;
            r_len   <= i_field_length;
            r_blank <= i_blank_field;
            r_last  <= i_last_field;
        end else if (r_state == S_LEN && r_work == '0) begin
            r_work <= r_val;
        end else if ((r_state == S_LEN) || (r_state == S_DROP && r_cnt != 4'd0) ||
                     (r_state == S_PLACE)) begin
            r_work <= VALUE_WIDTH'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_digit_count <= DIGIT_COUNT_RST;
            r_lz          <= 1'b0;
            r_fep         <= 6'd0;
            r_end         <= 6'd0;
            r_vlen        <= 4'd0;
            r_cnt         <= 4'd0;
            r_j           <= 5'd0;
            r_oi          <= 6'd0;
            r_valid       <= '0;
            r_strobe      <= 1'b0;
            r_seg         <= 8'd0;
            r_last_pat    <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_EMIT);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DIGIT_COUNT:   r_digit_count <= i_cfg_data;
                    REG_LEADING_ZEROS: r_lz <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_wr) begin
                r_valid[w_widx] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (w_end_sum > {1'b0, END_MAX}) begin
                            r_fep <= END_MAX;
                            r_end <= END_MAX;
                        end else begin
                            r_fep <= w_end_sum[5:0];
                            r_end <= w_end_sum[5:0];
                        end
                        r_vlen  <= 4'd0;
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (r_work == '0) begin
                        if ({1'b0, r_vlen} > r_len) begin
                            r_cnt <= 4'({1'b0, r_vlen} - r_len);
                        end else begin
                            r_cnt <= 4'd0;
                        end
                        r_state <= S_DROP;
                    end else begin
                        r_vlen <= r_vlen + 4'd1;
                    end
                end
                S_DROP: begin
                    if (r_cnt == 4'd0) begin
                        r_j     <= 5'd0;
                        r_state <= S_PLACE;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                S_PLACE: begin
                    if (r_j == r_len) begin
                        r_oi    <= 6'd0;
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_j <= r_j + 5'd1;
                    end
                end
                S_EMIT: begin
                    r_seg      <= seg_of(w_rcode);
                    r_last_pat <= (r_oi == w_digits - 6'd1);
                    if (r_oi == w_digits - 6'd1) begin
                        // frame out: store back to blank, placement restarts
                        r_valid <= '0;
                        r_fep   <= 6'd0;
                        r_state <= S_IDLE;
                    end else begin
                        r_oi <= r_oi + 6'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe          = r_strobe;
    assign o_segment_pattern = r_seg;
    assign o_last_pattern    = r_last_pat;

endmodule

>>> test/tb_seven_segment_field_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_field_formatter
// Self-checking bench for the seven-segment field formatter. A directed table
// covers reset defaults, field extremes, blanking, truncation and placement
// overflow. Random frames then run under several display settings. Segment
// bytes are checked against typed-in frames or an in-bench digit-store model.
// ----------------------------------------------------------------------------
module tb_seven_segment_field_formatter;
    import ssff_pkg::*;

    localparam int IDLE_LIMIT    = 500;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 26;
    localparam int N_DIRECTED    = 22;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // segment bytes for codes 0..9 and blank, code 0 in the low byte
    localparam logic [87:0] SEG_FONT = {8'd0, 8'd111, 8'd127, 8'd7, 8'd125,
                                        8'd109, 8'd102, 8'd79, 8'd91, 8'd6, 8'd63};

    typedef struct packed {
        logic [7:0] pattern;
        logic       tail;
    } t_seg_byte;

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  len;
        logic        blank;
        logic        last;
        logic        pin;
        logic [31:0] frame;
    } t_field_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic [31:0]           i_value = '0;
    logic [4:0]            i_field_length = '0;
    logic                  i_blank_field = 1'b0;
    logic                  i_last_field = 1'b0;
    logic                  o_strobe;
    logic [7:0]            o_segment_pattern;
    logic                  o_last_pattern;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // typed-in frame travelling alongside a directed field
    logic                  pin_on = 1'b0;
    logic [31:0]           pin_frame = '0;

    // display model
    logic [3:0]            digit_codes [MAX_DIGITS_DEF];
    logic [5:0]            field_end;
    logic [4:0]            shown_digits;
    logic                  zero_fill;
    t_seg_byte             segments_due [$];

    int                    n_fail = 0;
    int                    idle_cycles = 0;

    t_field_row            directed_rows [N_DIRECTED];

    seven_segment_field_formatter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_value           (i_value),
        .i_field_length    (i_field_length),
        .i_blank_field     (i_blank_field),
        .i_last_field      (i_last_field),
        .o_strobe          (o_strobe),
        .o_segment_pattern (o_segment_pattern),
        .o_last_pattern    (o_last_pattern),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic place_field(input logic [31:0] value, input logic [4:0] len,
                               input logic blank, input logic last,
                               input logic pin, input logic [31:0] frame);
        int unsigned val;
        int unsigned vlen;
        int unsigned fend;
        int unsigned width;
        int          idx;
        logic [3:0]  code;
        t_seg_byte   b;
        val  = value;
        vlen = 0;
        while (val != 0) begin
            vlen++;
            val /= 10;
        end
        val   = value;
        width = (shown_digits == 0) ? 1 :
                ((shown_digits > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : shown_digits);
        fend  = field_end + len;
        if (fend > END_MAX) fend = END_MAX;
        field_end = 6'(fend);
        // a value wider than its field drops its low digits
        if (vlen > len) repeat (vlen - len) val /= 10;
        for (int j = 0; j < len; j++) begin
            idx  = int'(width) - int'(fend) + j;
            code = 4'(val % 10);
            val /= 10;
            if (blank || (j >= vlen && !zero_fill)) code = BLANK_CODE;
            if (idx >= 0 && idx < int'(width)) digit_codes[idx] = code;
        end
        if (last) begin
            for (int j = 0; j < width; j++) begin
                b.pattern = pin ? frame[8*j +: 8] : SEG_FONT[8*digit_codes[j] +: 8];
                b.tail    = (j + 1 == width);
                segments_due.push_back(b);
            end
            foreach (digit_codes[i]) digit_codes[i] = BLANK_CODE;
            field_end = '0;
        end
    endtask

    // result checking, input and register tracking, watchdog
    always @(posedge i_clk) begin
        t_seg_byte due;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_strobe) begin
                moved = 1'b1;
                if (segments_due.size() == 0) begin
                    $error("unexpected result: segment_pattern %0d, last_pattern %0d",
                           o_segment_pattern, o_last_pattern);
                    n_fail++;
                end else begin
                    due = segments_due.pop_front();
                    if (o_segment_pattern !== due.pattern) begin
                        $error("segment_pattern: expected %0d, got %0d",
                               due.pattern, o_segment_pattern);
                        n_fail++;
                    end
                    if (o_last_pattern !== due.tail) begin
                        $error("last_pattern: expected %0d, got %0d",
                               due.tail, o_last_pattern);
                        n_fail++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    REG_DIGIT_COUNT:   shown_digits = i_cfg_data;
                    REG_LEADING_ZEROS: zero_fill = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                moved = 1'b1;
                place_field(i_value, i_field_length, i_blank_field, i_last_field,
                            pin_on, pin_frame);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $error("no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_field(input t_field_row f, input int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_value        <= f.value;
        i_field_length <= f.len;
        i_blank_field  <= f.blank;
        i_last_field   <= f.last;
        pin_on         <= f.pin;
        pin_frame      <= f.frame;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // hold the sender off until the frame has drained and the block is quiet
    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          dc_plan [PHASES];
        int          lz_plan [PHASES];
        int          sent;
        int          nf;
        int          rem;
        int          len;
        int          eff;
        int          d;
        int unsigned hi;
        bit          tidy;
        bit          quiet;
        logic [31:0] val;
        t_field_row  row;

        foreach (digit_codes[i]) digit_codes[i] = BLANK_CODE;
        field_end    = '0;
        shown_digits = DIGIT_COUNT_RST;
        zero_fill    = 1'b0;

        // reset display: four digits, leading zeros off; frames as {d3,d2,d1,d0}
        directed_rows = '{
            {32'd1234,        5'd4,  1'b0, 1'b1, 1'b1, {8'd6, 8'd91, 8'd79, 8'd102}},
            {32'd0,           5'd4,  1'b0, 1'b1, 1'b1, 32'd0},
            {32'hFFFF_FFFF,   5'd4,  1'b0, 1'b1, 1'b1, {8'd102, 8'd91, 8'd111, 8'd102}},
            {32'd99,          5'd0,  1'b0, 1'b1, 1'b1, 32'd0},
            {32'd8888,        5'd4,  1'b1, 1'b1, 1'b1, 32'd0},
            {32'd7,           5'd2,  1'b0, 1'b0, 1'b0, 32'd0},
            {32'd5,           5'd2,  1'b0, 1'b1, 1'b1, {8'd0, 8'd7, 8'd0, 8'd109}},
            {32'd1000000000,  5'd10, 1'b0, 1'b0, 1'b0, 32'd0},
            {32'd9,           5'd1,  1'b0, 1'b1, 1'b0, 32'd0},
            {32'h8000_0000,   5'd31, 1'b0, 1'b1, 1'b0, 32'd0},
            {32'd4321,        5'd17, 1'b1, 1'b0, 1'b0, 32'd0},
            {32'd10,          5'd3,  1'b0, 1'b1, 1'b0, 32'd0},
            // placement runs past the end of the store and saturates
            {32'd12345,       5'd16, 1'b0, 1'b0, 1'b0, 32'd0},
            {32'd12345,       5'd16, 1'b0, 1'b0, 1'b0, 32'd0},
            {32'd12345,       5'd16, 1'b0, 1'b0, 1'b0, 32'd0},
            {32'd12345,       5'd16, 1'b0, 1'b0, 1'b0, 32'd0},
            {32'd77,          5'd16, 1'b0, 1'b0, 1'b0, 32'd0},
            {32'd3,           5'd1,  1'b0, 1'b1, 1'b0, 32'd0},
            {32'd56,          5'd2,  1'b0, 1'b0, 1'b0, 32'd0},
            {32'd78,          5'd2,  1'b0, 1'b1, 1'b0, 32'd0},
            {32'h5555_5555,   5'd8,  1'b0, 1'b1, 1'b0, 32'd0},
            {32'hAAAA_AAAA,   5'd3,  1'b0, 1'b1, 1'b0, 32'd0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
            send_field(directed_rows[r], (r < 8) ? 0 : $urandom_range(0, 13));

        dc_plan = '{16, 1, 0, 31, 17, 7, 12, 0};
        lz_plan = '{1, 0, 1, 0, 1, 0, 1, 0};
        dc_plan[PHASES-1] = $urandom_range(0, 31);
        lz_plan[PHASES-1] = $urandom_range(0, 1);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_DIGIT_COUNT, CFG_DATA_W'(dc_plan[p]));
            write_reg(REG_LEADING_ZEROS, {4'($urandom_range(0, 15)), 1'(lz_plan[p])});
            if (p % 3 == 0) begin
                write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
                write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
            end
            i_cfg_valid <= 1'b0;
            eff = (dc_plan[p] == 0) ? 1 :
                  ((dc_plan[p] > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : dc_plan[p]);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // mostly frames that exactly fill the display, some loose noise
                tidy  = ($urandom_range(0, 9) < 7);
                quiet = ($urandom_range(0, 3) == 0);
                nf    = tidy ? $urandom_range(1, 4) : $urandom_range(1, 3);
                rem   = eff;
                for (int k = 0; k < nf; k++) begin
                    d = $urandom_range(0, 10);
                    if (d == 0) begin
                        val = '0;
                    end else if (d == 10) begin
                        val = $urandom;
                    end else begin
                        hi = 1;
                        repeat (d) hi = hi * 10;
                        val = $urandom_range(hi - 1, hi / 10);
                    end
                    if (tidy) begin
                        len = (k == nf - 1) ? rem : $urandom_range(0, rem);
                        rem -= len;
                        row = {val, 5'(len), 1'($urandom_range(0, 7) == 0),
                               1'(k == nf - 1), 1'b0, 32'd0};
                    end else begin
                        row = {val, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                               1'(k == nf - 1 && $urandom_range(0, 1) == 1), 1'b0, 32'd0};
                    end
                    send_field(row, quiet ? 0 : $urandom_range(0, 13));
                    sent++;
                end
            end
        end

        settle();
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ssff_pkg.sv
design/seven_segment_field_formatter.sv
test/tb_seven_segment_field_formatter.sv
